// ===== hdl/bas_pkg.sv =====
// shared types and constants for the buzzer alarm sequencer
// no dependencies; every other file uses this package by scoped names
package bas_pkg;

  // default widths of the timers and the round counter
  localparam int TIME_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 4;

  // configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BEEP_COUNT    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BEEP_ON_TIME  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BEEP_PERIOD   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DROP_ROUNDS   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DROP_ON_TIME  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DROP_GAP_TIME = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_TIME = 3'd6;

  localparam logic [3:0]  BEEP_COUNT_RST    = 4'd3;
  localparam logic [15:0] BEEP_ON_TIME_RST  = 16'd200;
  localparam logic [15:0] BEEP_PERIOD_RST   = 16'd500;
  localparam logic [3:0]  DROP_ROUNDS_RST   = 4'd5;
  localparam logic [15:0] DROP_ON_TIME_RST  = 16'd1000;
  localparam logic [15:0] DROP_GAP_TIME_RST = 16'd500;
  localparam logic [15:0] DEBOUNCE_TIME_RST = 16'd50;

  // item opcodes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_DROP = 2'd1;
  localparam logic [1:0] OP_ENV  = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_BEEP_ON  = 3'd1,
    MODE_BEEP_OFF = 3'd2,
    MODE_DROP_ON  = 3'd3,
    MODE_DROP_GAP = 3'd4
  } mode_t;

  typedef struct packed {
    logic [3:0]  beep_count;
    logic [15:0] beep_on_time;
    logic [15:0] beep_period;
    logic [3:0]  drop_rounds;
    logic [15:0] drop_on_time;
    logic [15:0] drop_gap_time;
    logic [15:0] debounce_time;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic       key_level;
  } in_t;

  typedef struct packed {
    logic tone_on;
    logic busy_res;
    logic drop_cancelled;
    logic drop_finished;
  } out_t;

endpackage

// ===== hdl/bas_cfg_regs.sv =====
// configuration register file of the buzzer alarm sequencer
// depends on bas_pkg
module bas_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bas_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bas_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output bas_pkg::cfg_t                       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.beep_count    <= bas_pkg::BEEP_COUNT_RST;
      cfg.beep_on_time  <= bas_pkg::BEEP_ON_TIME_RST;
      cfg.beep_period   <= bas_pkg::BEEP_PERIOD_RST;
      cfg.drop_rounds   <= bas_pkg::DROP_ROUNDS_RST;
      cfg.drop_on_time  <= bas_pkg::DROP_ON_TIME_RST;
      cfg.drop_gap_time <= bas_pkg::DROP_GAP_TIME_RST;
      cfg.debounce_time <= bas_pkg::DEBOUNCE_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bas_pkg::REG_BEEP_COUNT:    cfg.beep_count    <= cfg_data[3:0];
        bas_pkg::REG_BEEP_ON_TIME:  cfg.beep_on_time  <= cfg_data[15:0];
        bas_pkg::REG_BEEP_PERIOD:   cfg.beep_period   <= cfg_data[15:0];
        bas_pkg::REG_DROP_ROUNDS:   cfg.drop_rounds   <= cfg_data[3:0];
        bas_pkg::REG_DROP_ON_TIME:  cfg.drop_on_time  <= cfg_data[15:0];
        bas_pkg::REG_DROP_GAP_TIME: cfg.drop_gap_time <= cfg_data[15:0];
        bas_pkg::REG_DEBOUNCE_TIME: cfg.debounce_time <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/bas_debounce.sv =====
// cancel key debouncer, stepped once per tick during drop phases
// depends on bas_pkg for the default timer width
module bas_debounce #(
  parameter int TIME_BITS = bas_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 key_level,
  input  logic [TIME_BITS-1:0] limit,
  output logic                 press
);

  logic                 armed;
  logic                 latched;
  logic [TIME_BITS-1:0] key_timer;
  logic [TIME_BITS-1:0] key_timer_inc;

  // saturating count
  assign key_timer_inc = (key_timer == '1) ? key_timer : key_timer + TIME_BITS'(1);
  assign press = !latched && key_level && armed && (key_timer_inc >= limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= 1'b0;
      latched   <= 1'b0;
      key_timer <= '0;
    end else if (step) begin
      if (!latched) begin
        if (key_level) begin
          if (!armed) begin
            armed     <= 1'b1;
            key_timer <= '0;
          end else begin
            key_timer <= key_timer_inc;
            if (key_timer_inc >= limit) begin
              latched <= 1'b1;
              armed   <= 1'b0;
            end
          end
        end else begin
          armed <= 1'b0;
        end
      end else if (!key_level) begin
        latched <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/bas_sequencer.sv =====
// pattern state machine: beep and drop phases, held request slot, result forming
// depends on bas_pkg and bas_debounce
module bas_sequencer #(
  parameter int TIME_BITS  = bas_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = bas_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  bas_pkg::in_t  item,
  input  bas_pkg::cfg_t cfg,
  output bas_pkg::out_t res
);

  localparam logic [32:0] TIME_MAX  = (33'd1 << TIME_BITS) - 33'd1;
  localparam logic [8:0]  COUNT_MAX = (9'd1 << COUNT_BITS) - 9'd1;

  typedef struct packed {
    logic                  ended;
    logic                  on;
    logic [TIME_BITS-1:0]  t;
    logic [COUNT_BITS-1:0] r;
  } step_t;

  function automatic logic [TIME_BITS-1:0] clip_time(input logic [15:0] v);
    logic [32:0] wide;
    wide = 33'(v);
    if (wide > TIME_MAX) return '1;
    return wide[TIME_BITS-1:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] clip_count(input logic [3:0] v);
    logic [8:0] wide;
    wide = 9'(v);
    if (wide > COUNT_MAX) return '1;
    return wide[COUNT_BITS-1:0];
  endfunction

  // runs a pattern forward through every phase whose limit is already met;
  // zero-length phases chain, a phase with a nonzero limit entered at zero stops it
  function automatic step_t resolve(input logic                  on,
                                    input logic [TIME_BITS-1:0]  t,
                                    input logic [COUNT_BITS-1:0] r,
                                    input logic [TIME_BITS-1:0]  a,
                                    input logic [TIME_BITS-1:0]  b,
                                    input logic [COUNT_BITS-1:0] n);
    step_t           s;
    logic [COUNT_BITS:0] r1;
    logic [COUNT_BITS:0] r2;
    logic [COUNT_BITS:0] nn;
    s.ended = 1'b0;
    s.on    = on;
    s.t     = t;
    s.r     = r;
    r1      = {1'b0, r} + (COUNT_BITS+1)'(1);
    r2      = r1 + (COUNT_BITS+1)'(1);
    nn      = {1'b0, n};
    if (on) begin
      if (t >= a) begin
        if (r1 >= nn) begin
          s.ended = 1'b1;
        end else if (b != '0) begin
          s.on = 1'b0;
          s.t  = '0;
        end else if (a != '0) begin
          s.t = '0;
          s.r = r1[COUNT_BITS-1:0];
        end else begin
          s.ended = 1'b1;
        end
      end
    end else begin
      if (t >= b) begin
        if (r1 >= nn) begin
          s.ended = 1'b1;
        end else if (a != '0) begin
          s.on = 1'b1;
          s.t  = '0;
          s.r  = r1[COUNT_BITS-1:0];
        end else if (r2 >= nn) begin
          s.ended = 1'b1;
        end else if (b != '0) begin
          s.t = '0;
          s.r = r1[COUNT_BITS-1:0];
        end else begin
          s.ended = 1'b1;
        end
      end
    end
    return s;
  endfunction

  bas_pkg::mode_t        mode, mode_next;
  logic [TIME_BITS-1:0]  phase_timer, phase_timer_next;
  logic [COUNT_BITS-1:0] round_count, round_count_next;
  logic                  held, held_next;
  logic                  drop_held, drop_held_next;

  logic [TIME_BITS-1:0]  beep_on_lim, beep_off_lim, drop_on_lim, drop_gap_lim, deb_lim;
  logic [COUNT_BITS-1:0] nb, nd;
  logic [15:0]           beep_off_raw;

  logic tick, req, drop_req;
  logic is_beep, is_drop, cur_on;
  logic key_step, press, cancel;
  logic [TIME_BITS-1:0]  t_tick;
  logic [TIME_BITS-1:0]  a_cur, b_cur, a_new, b_new;
  logic [COUNT_BITS-1:0] n_cur, n_new;
  step_t res_cur, res_new;
  logic start_drop, idle_after, fin;

  assign beep_off_raw = (cfg.beep_period > cfg.beep_on_time) ?
                        cfg.beep_period - cfg.beep_on_time : 16'd0;
  assign beep_on_lim  = clip_time(cfg.beep_on_time);
  assign beep_off_lim = clip_time(beep_off_raw);
  assign drop_on_lim  = clip_time(cfg.drop_on_time);
  assign drop_gap_lim = clip_time(cfg.drop_gap_time);
  assign deb_lim      = clip_time(cfg.debounce_time);
  assign nb           = clip_count(cfg.beep_count);
  assign nd           = clip_count(cfg.drop_rounds);

  assign tick     = fire && (item.op == bas_pkg::OP_TICK);
  assign drop_req = fire && (item.op == bas_pkg::OP_DROP);
  assign req      = drop_req || (fire && (item.op == bas_pkg::OP_ENV));

  always_comb begin
    unique case (mode)
      bas_pkg::MODE_BEEP_ON:  begin is_beep = 1'b1; is_drop = 1'b0; cur_on = 1'b1; end
      bas_pkg::MODE_BEEP_OFF: begin is_beep = 1'b1; is_drop = 1'b0; cur_on = 1'b0; end
      bas_pkg::MODE_DROP_ON:  begin is_beep = 1'b0; is_drop = 1'b1; cur_on = 1'b1; end
      bas_pkg::MODE_DROP_GAP: begin is_beep = 1'b0; is_drop = 1'b1; cur_on = 1'b0; end
      default:                begin is_beep = 1'b0; is_drop = 1'b0; cur_on = 1'b0; end
    endcase
  end

  assign key_step = tick && is_drop;
  assign cancel   = key_step && press;

  bas_debounce #(
    .TIME_BITS (TIME_BITS)
  ) u_debounce (
    .clk       (clk),
    .rst       (rst),
    .step      (key_step),
    .key_level (item.key_level),
    .limit     (deb_lim),
    .press     (press)
  );

  assign t_tick = (phase_timer == '1) ? phase_timer : phase_timer + TIME_BITS'(1);

  assign a_cur   = is_drop ? drop_on_lim  : beep_on_lim;
  assign b_cur   = is_drop ? drop_gap_lim : beep_off_lim;
  assign n_cur   = is_drop ? nd : nb;
  assign res_cur = resolve(cur_on, t_tick, round_count, a_cur, b_cur, n_cur);

  assign start_drop = drop_held || drop_req;
  assign a_new   = start_drop ? drop_on_lim  : beep_on_lim;
  assign b_new   = start_drop ? drop_gap_lim : beep_off_lim;
  assign n_new   = start_drop ? nd : nb;
  assign res_new = resolve(1'b1, '0, '0, a_new, b_new, n_new);

  always_comb begin
    mode_next        = mode;
    phase_timer_next = phase_timer;
    round_count_next = round_count;
    held_next        = held;
    drop_held_next   = drop_held;
    idle_after       = 1'b0;
    fin              = 1'b0;
    if (fire) begin
      held_next      = held || req;
      drop_held_next = start_drop;
      if (tick) begin
        if (cancel) begin
          mode_next  = bas_pkg::MODE_IDLE;
          fin        = 1'b1;
          idle_after = 1'b1;
        end else if (is_beep || is_drop) begin
          phase_timer_next = res_cur.t;
          round_count_next = res_cur.r;
          if (res_cur.ended) begin
            mode_next  = bas_pkg::MODE_IDLE;
            fin        = is_drop;
            idle_after = 1'b1;
          end else if (is_drop) begin
            mode_next = res_cur.on ? bas_pkg::MODE_DROP_ON : bas_pkg::MODE_DROP_GAP;
          end else begin
            mode_next = res_cur.on ? bas_pkg::MODE_BEEP_ON : bas_pkg::MODE_BEEP_OFF;
          end
        end else begin
          idle_after = 1'b1;
        end
      end else if (req && (mode == bas_pkg::MODE_IDLE)) begin
        idle_after = 1'b1;
      end
      // the held request starts in the same item in which the pattern ends
      if (idle_after && held_next) begin
        held_next        = 1'b0;
        drop_held_next   = 1'b0;
        phase_timer_next = res_new.t;
        round_count_next = res_new.r;
        if ((n_new == '0) || res_new.ended) begin
          mode_next = bas_pkg::MODE_IDLE;
          if (start_drop) fin = 1'b1;
        end else if (start_drop) begin
          mode_next = res_new.on ? bas_pkg::MODE_DROP_ON : bas_pkg::MODE_DROP_GAP;
        end else begin
          mode_next = res_new.on ? bas_pkg::MODE_BEEP_ON : bas_pkg::MODE_BEEP_OFF;
        end
      end
    end
    res.tone_on        = (mode_next == bas_pkg::MODE_BEEP_ON) ||
                         (mode_next == bas_pkg::MODE_DROP_ON);
    res.busy_res       = (mode_next != bas_pkg::MODE_IDLE);
    res.drop_cancelled = cancel;
    res.drop_finished  = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= bas_pkg::MODE_IDLE;
      phase_timer <= '0;
      round_count <= '0;
      held        <= 1'b0;
      drop_held   <= 1'b0;
    end else begin
      mode        <= mode_next;
      phase_timer <= phase_timer_next;
      round_count <= round_count_next;
      held        <= held_next;
      drop_held   <= drop_held_next;
    end
  end

`ifndef SYNTHESIS
  a_cancel_finishes: assert property (@(posedge clk) disable iff (rst)
    res.drop_cancelled |-> res.drop_finished)
    else $error("cancel without finish");

  a_tone_busy: assert property (@(posedge clk) disable iff (rst)
    res.tone_on |-> res.busy_res)
    else $error("tone while not busy");

  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    (mode == bas_pkg::MODE_IDLE) |-> !held)
    else $error("request left held while idle");

  a_drop_held_flag: assert property (@(posedge clk) disable iff (rst)
    drop_held |-> held)
    else $error("drop flag without held request");

  a_pulse_needs_item: assert property (@(posedge clk) disable iff (rst)
    !fire |-> !(res.drop_cancelled || res.drop_finished))
    else $error("pulse without an item");
`endif

endmodule

// ===== hdl/buzzer_alarm_sequencer_top.sv =====
// Buzzer alarm sequencer: plays environment beep patterns and drop alarm rounds from
// millisecond tick items, with a debounced cancel key during drop phases. One item is
// taken per clock cycle while the output is not stalled; each item gives one result,
// passing through an input register and a result register with the whole state
// update between them. The output register holds a result under stall while the next
// item is taken. No clearing pass after reset.
// depends on bas_pkg, bas_cfg_regs, bas_sequencer
module buzzer_alarm_sequencer_top #(
  parameter int TIME_BITS  = bas_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = bas_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bas_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bas_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bas_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bas_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  bas_pkg::cfg_t cfg;
  bas_pkg::in_t  in_reg;
  logic          in_reg_valid;
  bas_pkg::out_t res;
  logic          fire;

  // the item in the input register is processed when the result register frees up
  assign fire     = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !fire;

  bas_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bas_sequencer #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_reg),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_reg_valid <= 1'b1;
    end else if (fire) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= res;
    end
  end

endmodule
